// ===== src/mht_pkg.sv =====
// Shared types and constants for the message header tokenizer.
`default_nettype none

package mht_pkg;

    // Byte codes that steer the parser
    localparam logic [7:0] CH_SP    = 8'd32;
    localparam logic [7:0] CH_COLON = 8'd58;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;

    // Token record kinds
    localparam logic [2:0] KIND_WORD1      = 3'd0;
    localparam logic [2:0] KIND_WORD2      = 3'd1;
    localparam logic [2:0] KIND_REST       = 3'd2;
    localparam logic [2:0] KIND_NAME       = 3'd3;
    localparam logic [2:0] KIND_VALUE      = 3'd4;
    localparam logic [2:0] KIND_HDR_END    = 3'd5;
    localparam logic [2:0] KIND_INCOMPLETE = 3'd6;
    localparam logic [2:0] KIND_OVERFLOW   = 3'd7;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_SKIP0 = 4'd1,
        PH_WORD1 = 4'd2,
        PH_SKIP1 = 4'd3,
        PH_WORD2 = 4'd4,
        PH_SKIP2 = 4'd5,
        PH_REST  = 4'd6,
        PH_HSKIP = 4'd7,
        PH_LINE  = 4'd8,
        PH_NAME  = 4'd9,
        PH_VSKIP = 4'd10,
        PH_VAL   = 4'd11
    } phase_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic        last_byte;
        logic [15:0] start_offset;
    } item_t;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [15:0] token_start;
        logic [15:0] token_end;
        logic [5:0]  field_index;
    } record_t;

endpackage

`default_nettype wire

// ===== src/mht_parse.sv =====
// Parser state registers and the per-byte phase update.
`default_nettype none

module mht_parse #(
    parameter int MAX_HEADERS = 64,
    parameter int POS_BITS    = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start_line_enable,
    input  wire mht_pkg::item_t  item,
    input  wire logic            advance,
    output mht_pkg::record_t     rec,
    output logic                 rec_valid
);
    import mht_pkg::*;

    localparam int HC_W = $clog2(MAX_HEADERS + 1);

    phase_t              phase_reg, phase_next, phase_c;
    logic [POS_BITS-1:0] position_reg, position_next, pos_c;
    logic [POS_BITS-1:0] token_begin_reg, token_begin_next;
    logic [HC_W-1:0]     header_count_reg, header_count_next;
    logic                after_cr_reg, after_cr_next;

    logic                active;
    logic                do_name;
    logic                hit;
    logic [2:0]          kind_c;
    logic [HC_W-1:0]     fidx_c;
    logic [31:0]         off32;
    logic [31:0]         tb32;
    logic [31:0]         pos32;
    logic [31:0]         fidx32;
    logic [7:0]          b;

    assign b     = item.data_byte;
    assign off32 = 32'(item.start_offset);

    always_comb
    begin
        phase_c           = phase_reg;
        pos_c             = position_reg;
        token_begin_next  = token_begin_reg;
        header_count_next = header_count_reg;
        after_cr_next     = after_cr_reg;
        do_name           = 1'b0;
        hit               = 1'b0;
        kind_c            = KIND_WORD1;
        fidx_c            = '0;

        // A first byte restarts parsing, even mid-message
        if (item.first_byte)
        begin
            pos_c             = off32[POS_BITS-1:0];
            header_count_next = '0;
            after_cr_next     = 1'b0;
            token_begin_next  = off32[POS_BITS-1:0];
            phase_c           = start_line_enable ? PH_SKIP0 : PH_HSKIP;
        end

        active     = (phase_c != PH_IDLE);
        phase_next = phase_c;

        unique case (phase_c)
            PH_SKIP0:
                if (b > CH_SP)
                begin
                    token_begin_next = pos_c;
                    phase_next       = PH_WORD1;
                end
            PH_SKIP1:
                if (b > CH_SP)
                begin
                    token_begin_next = pos_c;
                    phase_next       = PH_WORD2;
                end
            PH_SKIP2:
                if (b > CH_SP)
                begin
                    token_begin_next = pos_c;
                    phase_next       = PH_REST;
                end
            PH_WORD1:
                if (b == CH_SP)
                begin
                    hit        = 1'b1;
                    kind_c     = KIND_WORD1;
                    phase_next = PH_SKIP1;
                end
            PH_WORD2:
                if (b == CH_SP)
                begin
                    hit        = 1'b1;
                    kind_c     = KIND_WORD2;
                    phase_next = PH_SKIP2;
                end
            PH_REST:
                if (b == CH_CR)
                begin
                    hit        = 1'b1;
                    kind_c     = KIND_REST;
                    phase_next = PH_HSKIP;
                end
            PH_HSKIP:
                if (b != CH_CR && b != CH_LF)
                    do_name = 1'b1;
            PH_LINE:
            begin
                after_cr_next = 1'b0;
                // drop the LF that follows a value's CR
                if (!(after_cr_reg && b == CH_LF))
                    do_name = 1'b1;
            end
            PH_NAME:
                do_name = 1'b1;
            PH_VSKIP:
                if (b > CH_SP)
                begin
                    token_begin_next = pos_c;
                    phase_next       = PH_VAL;
                end
            PH_VAL:
                if (b == CH_CR)
                begin
                    hit               = 1'b1;
                    kind_c            = KIND_VALUE;
                    fidx_c            = header_count_next;
                    header_count_next = header_count_next + 1'b1;
                    after_cr_next     = 1'b1;
                    phase_next        = PH_LINE;
                end
            default:
                phase_next = PH_IDLE;
        endcase

        // Name byte: a line start opens a name; colon closes it, CR ends the header
        if (do_name)
        begin
            if (phase_c != PH_NAME)
                token_begin_next = pos_c;
            phase_next = PH_NAME;
            if (b == CH_COLON)
            begin
                hit = 1'b1;
                if (header_count_next >= HC_W'(MAX_HEADERS))
                begin
                    kind_c     = KIND_OVERFLOW;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    kind_c     = KIND_NAME;
                    fidx_c     = header_count_next;
                    phase_next = PH_VSKIP;
                end
            end
            else if (b == CH_CR)
            begin
                hit        = 1'b1;
                kind_c     = KIND_HDR_END;
                phase_next = PH_IDLE;
            end
        end

        // Out of bytes before the header finished
        if (active && item.last_byte && phase_next != PH_IDLE)
        begin
            hit        = 1'b1;
            kind_c     = KIND_INCOMPLETE;
            phase_next = PH_IDLE;
        end

        position_next = active ? pos_c + 1'b1 : position_reg;
    end

    assign tb32   = 32'(token_begin_next);
    assign pos32  = 32'(pos_c);
    assign fidx32 = (kind_c == KIND_NAME || kind_c == KIND_VALUE) ? 32'(fidx_c) : 32'd0;

    assign rec_valid       = hit;
    assign rec.token_kind  = kind_c;
    assign rec.token_start = tb32[15:0];
    assign rec.token_end   = pos32[15:0];
    assign rec.field_index = fidx32[5:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            position_reg     <= '0;
            token_begin_reg  <= '0;
            header_count_reg <= '0;
            after_cr_reg     <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg        <= phase_next;
            position_reg     <= position_next;
            token_begin_reg  <= token_begin_next;
            header_count_reg <= header_count_next;
            after_cr_reg     <= after_cr_next;
        end
    end

    a_hc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        header_count_reg <= HC_W'(MAX_HEADERS))
        else $error("header count beyond limit");

    a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(phase_reg) && $stable(position_reg))
        else $error("parser state moved without a word");

    a_name_on_colon: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && rec.token_kind == KIND_NAME |-> b == CH_COLON)
        else $error("name record without colon");

endmodule

`default_nettype wire

// ===== src/mht_out_reg.sv =====
// Result register between the parser and the output stream.
`default_nettype none

module mht_out_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire mht_pkg::record_t  rec,
    output logic                   free,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [39:0]            m_axis_tdata,  // token_start, token_end, field_index, zero pad
    output logic [2:0]             m_axis_tuser   // token_kind
);
    import mht_pkg::*;

    logic    valid_reg, valid_next;
    record_t rec_reg;

    assign free       = !valid_reg || m_axis_tready;
    assign valid_next = load ? 1'b1 : (m_axis_tready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            rec_reg <= rec;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tuser  = rec_reg.token_kind;
    assign m_axis_tdata  = {2'b00, rec_reg.field_index, rec_reg.token_end, rec_reg.token_start};

endmodule

`default_nettype wire

// ===== src/message_header_tokenizer.sv =====
// Top level of the message header tokenizer: input register, parser and result register.
//
// The block takes a message one byte per word and reports token boundaries as
// position records: the two words and the rest of an optional start line, then the
// name and value of each header field, and finally a header end, an incomplete
// (ran out of bytes) or an overflow (too many fields) record. A word with tuser set
// restarts parsing at the position given in its start_offset; tlast marks the last
// byte available. The block sustains one byte per clock unless the parser stage stalls.
// A byte is registered on entry, the phase update and byte compares run in the single
// parser stage, and a record is loaded into the result register, which presents it on
// the output. The parser stage stalls only when a byte produces a record while the
// result register still holds one that has not been taken; bytes that produce no
// record keep flowing. start_line_enable (reset 1) is written over the cfg port; the
// user must write it only while the block is idle, which the block does not enforce.
`default_nettype none

module message_header_tokenizer #(
    parameter int MAX_HEADERS = 64,
    parameter int POS_BITS    = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,       // start_line_enable
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // data_byte, start_offset
    input  wire logic        s_axis_tuser,   // first_byte
    input  wire logic        s_axis_tlast,   // last_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // token_start, token_end, field_index, zero pad
    output logic [2:0]       m_axis_tuser    // token_kind
);
    import mht_pkg::*;

    logic    start_line_enable_reg, start_line_enable_next;
    logic    in_valid_reg, in_valid_next;
    item_t   item_reg;
    item_t   item_in;
    record_t rec;
    logic    rec_valid;
    logic    out_free;
    logic    advance;
    logic    take;

    // Config register: always ready; the user writes it only while idle (not enforced here)
    assign cfg_ready              = 1'b1;
    assign start_line_enable_next = cfg_valid ? cfg_data : start_line_enable_reg;

    // Advance the held byte unless its record would collide with an untaken one
    assign advance       = in_valid_reg && (!rec_valid || out_free);
    assign s_axis_tready = !in_valid_reg || advance;
    assign take          = s_axis_tvalid && s_axis_tready;
    assign in_valid_next = take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);

    assign item_in.data_byte    = s_axis_tdata[7:0];
    assign item_in.first_byte   = s_axis_tuser;
    assign item_in.last_byte    = s_axis_tlast;
    assign item_in.start_offset = s_axis_tdata[23:8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_line_enable_reg <= 1'b1;
            in_valid_reg          <= 1'b0;
        end
        else
        begin
            start_line_enable_reg <= start_line_enable_next;
            in_valid_reg          <= in_valid_next;
        end
    end

    // Hold the byte word until the parser takes it
    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= item_in;
    end

    mht_parse #(
        .MAX_HEADERS (MAX_HEADERS),
        .POS_BITS    (POS_BITS)
    ) u_parse (
        .clk               (clk),
        .rst_n             (rst_n),
        .start_line_enable (start_line_enable_reg),
        .item              (item_reg),
        .advance           (advance),
        .rec               (rec),
        .rec_valid         (rec_valid)
    );

    mht_out_reg u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (advance && rec_valid),
        .rec           (rec),
        .free          (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(item_reg))
        else $error("held byte word lost");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !(advance && rec_valid))
        else $error("record overwrote an untaken result");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |-> rec_valid && m_axis_tvalid)
        else $error("byte stalled without a pending result");

endmodule

`default_nettype wire
